// ===== design/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg
// Shared constants for the contour ring closer: coordinate widths, register
// indexes and reset values.
// ----------------------------------------------------------------------------
package crc_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int CW     = 23;
  localparam int OUTW   = 22;
  localparam int INW    = 24;
  localparam int CANVW  = 14;
  localparam int OVLW   = 11;
  localparam int WALKW  = 16;
  localparam int CFGDW  = 14;
  localparam int CFGIW  = 2;

  localparam logic [CANVW-1:0] RST_CANVAS_W = 14'd1024;
  localparam logic [CANVW-1:0] RST_CANVAS_H = 14'd1024;
  localparam logic [OVLW-1:0]  RST_OVERLAP  = 11'd512;

  typedef enum logic [CFGIW-1:0] {
    REG_CANVAS_W = 2'd0,
    REG_CANVAS_H = 2'd1,
    REG_OVERLAP  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } point_t;

endpackage

// ===== design/contour_ring_closer.sv =====
// ----------------------------------------------------------------------------
// contour_ring_closer
// Collects polygon vertices and emits them as a closed ring with an overshoot,
// or rejects a ring of fewer than three kept vertices.
// A finite vertex word keeps the block busy after it is taken, for two
// squarings on the shared multiplier, a sum and a near-point compare, and
// then while the vertex is stored. The first vertex of a polygon goes
// straight to the store, and a non-finite vertex is dropped. The block takes
// no new word meanwhile. The word that ends a polygon then emits the run: a
// closing test, each ring point read from the store and emitted, and each
// overshoot point, measured with the shared squarer and the two-bits-per-cycle
// square root. A stalled output holds the run.
module contour_ring_closer
  import crc_pkg::*;
#(
  parameter int MAX_POINTS = crc_pkg::DEF_MAX_POINTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [crc_pkg::INW-1:0]    in_vertex_x,
  input  logic [crc_pkg::INW-1:0]    in_vertex_y,
  input  logic                       in_vertex_finite,
  input  logic                       in_last_vertex,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [crc_pkg::OUTW-1:0]   out_point_x,
  output logic [crc_pkg::OUTW-1:0]   out_point_y,
  output logic                       out_end_of_ring,
  output logic                       out_ring_rejected,
  output logic                       out_vertex_overflow,
  input  logic                       cfg_we,
  input  logic [crc_pkg::CFGIW-1:0]  cfg_index,
  input  logic [crc_pkg::CFGDW-1:0]  cfg_data
);

  localparam int FRAC_BITS = DEF_FRAC_BITS;
  localparam int DEPTH = MAX_POINTS - 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_POINTS + 1);
  localparam int DW    = 2 * CW + 2;
  localparam int RW    = DW / 2;
  localparam int ITW   = $clog2(RW);
  localparam int SMW   = 2 * FRAC_BITS + 1;
  localparam int SCW   = SMW + 14;
  localparam int HW    = CANVW + FRAC_BITS;
  localparam int LW    = (HW > CW) ? HW : CW;
  localparam logic [CW-1:0]  ONE     = CW'(1) << FRAC_BITS;
  localparam logic [SCW-1:0] ONE2    = SCW'(1) << (2 * FRAC_BITS);
  localparam logic [SCW-1:0] TENK    = SCW'(10000);
  localparam logic [KW-1:0]  K_MAX   = KW'(MAX_POINTS);
  localparam logic [KW-1:0]  K_DEPTH = KW'(DEPTH);
  localparam logic [KW-1:0]  K_THREE = KW'(3);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_SQX     = 16'h0002,
    S_SQY     = 16'h0004,
    S_SUM     = 16'h0008,
    S_CMP     = 16'h0010,
    S_KEEP    = 16'h0020,
    S_RUN     = 16'h0040,
    S_REJ     = 16'h0080,
    S_RD      = 16'h0100,
    S_RE      = 16'h0200,
    S_OS_RD   = 16'h0400,
    S_OS_GOT  = 16'h0800,
    S_SQRT    = 16'h1000,
    S_OS_ACC  = 16'h2000,
    S_OS_EMIT = 16'h4000
  } state_t;

  typedef enum logic [1:0] {
    M_NEAR = 2'd0,
    M_FAR  = 2'd1,
    M_SEG  = 2'd2
  } mode_t;

  state_t              state_r;
  mode_t               mode_r;
  logic [CANVW-1:0]    canvas_w_r;
  logic [CANVW-1:0]    canvas_h_r;
  logic [OVLW-1:0]     overlap_r;
  point_t              mem [DEPTH];
  point_t              rd_r;
  point_t              pa_r;
  point_t              pb_r;
  point_t              first_r;
  point_t              last_kept_r;
  point_t              prev_r;
  logic [KW-1:0]       kept_r;
  logic                ovf_r;
  logic [WALKW-1:0]    walked_r;
  logic                last_r;
  logic [2*CW-1:0]     prod_r;
  logic [2*CW-1:0]     acc_r;
  logic [DW-1:0]       dsq_r;
  logic                big_r;
  logic [RW+1:0]       rem_r;
  logic [RW-1:0]       root_r;
  logic [ITW-1:0]      it_r;
  logic [KW-1:0]       rs_r;
  logic [KW-1:0]       k_r;
  logic [KW-1:0]       idx_r;
  logic                out_valid_r;
  logic [OUTW-1:0]     out_x_r;
  logic [OUTW-1:0]     out_y_r;
  logic                out_end_r;
  logic                out_rej_r;
  logic                out_ovf_r;

  logic [CW-1:0]       clamp_x;
  logic [CW-1:0]       clamp_y;
  logic [CW-1:0]       dx;
  logic [CW-1:0]       dy;
  logic [CW-1:0]       mul_in;
  logic [2*CW-1:0]     mul_out;
  logic [SCW-1:0]      scaled;
  logic                near;
  logic                far;
  logic [RW+1:0]       rem_sh;
  logic [RW+1:0]       trial;
  logic                sq_ge;
  logic [RW:0]         walk_sum;
  logic                out_free;
  logic                out_fire;
  logic                ring_end;
  logic                os_end;
  point_t              ring_pt;

  always_comb begin
    logic [LW-1:0] hi_x;
    logic [LW-1:0] hi_y;
    logic [LW-1:0] vx;
    logic [LW-1:0] vy;
    hi_x = LW'(canvas_w_r) << FRAC_BITS;
    hi_y = LW'(canvas_h_r) << FRAC_BITS;
    vx   = LW'(in_vertex_x[CW-1:0]);
    vy   = LW'(in_vertex_y[CW-1:0]);
    if (in_vertex_x[INW-1]) begin
      clamp_x = '0;
    end else if (vx > hi_x) begin
      clamp_x = hi_x[CW-1:0];
    end else begin
      clamp_x = vx[CW-1:0];
    end
    if (in_vertex_y[INW-1]) begin
      clamp_y = '0;
    end else if (vy > hi_y) begin
      clamp_y = hi_y[CW-1:0];
    end else begin
      clamp_y = vy[CW-1:0];
    end
  end

  assign dx      = (pa_r.x > pb_r.x) ? pa_r.x - pb_r.x : pb_r.x - pa_r.x;
  assign dy      = (pa_r.y > pb_r.y) ? pa_r.y - pb_r.y : pb_r.y - pa_r.y;
  assign mul_in  = (state_r == S_SQX) ? dx : dy;
  assign mul_out = (2*CW)'(mul_in) * (2*CW)'(mul_in);

  assign scaled = SCW'(dsq_r[SMW-1:0]) * TENK;
  assign near   = !big_r && (scaled < ONE2);
  assign far    = big_r || (scaled > ONE2);

  assign rem_sh   = {rem_r[RW-1:0], dsq_r[DW-1:DW-2]};
  assign trial    = {root_r, 2'b01};
  assign sq_ge    = rem_sh >= trial;
  assign walk_sum = (RW+1)'(walked_r) + (RW+1)'(root_r);

  assign out_free = !out_valid_r || !out_stall;
  assign out_fire = out_free && ((state_r == S_REJ) || (state_r == S_RE)
                                 || (state_r == S_OS_EMIT));
  assign ring_pt  = (k_r == kept_r) ? first_r : rd_r;
  assign ring_end = (overlap_r == '0) || (rs_r >= K_MAX);
  assign os_end   = !((idx_r + KW'(1) < rs_r) && ((WALKW)'(overlap_r) > walked_r)
                      && (k_r + KW'(1) < K_MAX));

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= RST_CANVAS_W;
      canvas_h_r <= RST_CANVAS_H;
      overlap_r  <= RST_OVERLAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_W: canvas_w_r <= cfg_data;
        REG_CANVAS_H: canvas_h_r <= cfg_data;
        REG_OVERLAP:  overlap_r  <= cfg_data[OVLW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_KEEP && kept_r < K_DEPTH) begin
      mem[kept_r[AW-1:0]] <= pa_r;
    end
    if (state_r == S_RD && k_r < kept_r) begin
      rd_r <= mem[k_r[AW-1:0]];
    end else if (state_r == S_OS_RD && idx_r < kept_r) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_SQX: begin
        prod_r <= mul_out;
        big_r  <= (dx >= ONE) || (dy >= ONE);
      end
      S_SQY: begin
        acc_r  <= prod_r;
        prod_r <= mul_out;
      end
      S_SUM: begin
        dsq_r  <= DW'(acc_r) + DW'(prod_r);
        rem_r  <= '0;
        root_r <= '0;
      end
      S_SQRT: begin
        dsq_r  <= dsq_r << 2;
        rem_r  <= sq_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[RW-2:0], sq_ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_NEAR;
      kept_r      <= '0;
      last_kept_r <= '0;
      ovf_r       <= 1'b0;
      walked_r    <= '0;
      out_valid_r <= 1'b0;
      it_r        <= '0;
      k_r         <= '0;
      idx_r       <= '0;
      rs_r        <= '0;
      last_r      <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pa_r   <= '{x: clamp_x, y: clamp_y};
            pb_r   <= last_kept_r;
            last_r <= in_last_vertex;
            mode_r <= M_NEAR;
            if (!in_vertex_finite) begin
              state_r <= in_last_vertex ? S_RUN : S_IDLE;
            end else if (kept_r == '0) begin
              state_r <= S_KEEP;
            end else begin
              state_r <= S_SQX;
            end
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: state_r <= S_SUM;
        S_SUM: begin
          it_r    <= '0;
          state_r <= (mode_r == M_SEG) ? S_SQRT : S_CMP;
        end
        S_CMP: begin
          if (mode_r == M_FAR) begin
            rs_r    <= kept_r + KW'(far);
            k_r     <= '0;
            state_r <= S_RD;
          end else if (!near) begin
            state_r <= S_KEEP;
          end else begin
            state_r <= last_r ? S_RUN : S_IDLE;
          end
        end
        S_KEEP: begin
          if (kept_r < K_DEPTH) begin
            kept_r      <= kept_r + KW'(1);
            last_kept_r <= pa_r;
            if (kept_r == '0) begin
              first_r <= pa_r;
            end
          end else begin
            ovf_r <= 1'b1;
          end
          state_r <= last_r ? S_RUN : S_IDLE;
        end
        S_RUN: begin
          if (kept_r < K_THREE) begin
            state_r <= S_REJ;
          end else begin
            pa_r    <= first_r;
            pb_r    <= last_kept_r;
            mode_r  <= M_FAR;
            state_r <= S_SQX;
          end
        end
        S_REJ: begin
          if (out_free) begin
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_end_r   <= 1'b1;
            out_rej_r   <= 1'b1;
            out_ovf_r   <= ovf_r;
            kept_r      <= '0;
            last_kept_r <= '0;
            ovf_r       <= 1'b0;
            walked_r    <= '0;
            state_r     <= S_IDLE;
          end
        end
        S_RD: state_r <= S_RE;
        S_RE: begin
          if (out_free) begin
            out_x_r     <= ring_pt.x[OUTW-1:0];
            out_y_r     <= ring_pt.y[OUTW-1:0];
            out_end_r   <= (k_r + KW'(1) == rs_r) && ring_end;
            out_rej_r   <= 1'b0;
            out_ovf_r   <= ovf_r;
            k_r         <= k_r + KW'(1);
            if (k_r + KW'(1) == rs_r) begin
              if (ring_end) begin
                kept_r      <= '0;
                last_kept_r <= '0;
                ovf_r       <= 1'b0;
                walked_r    <= '0;
                state_r     <= S_IDLE;
              end else begin
                idx_r    <= KW'(1);
                prev_r   <= first_r;
                walked_r <= '0;
                state_r  <= S_OS_RD;
              end
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_OS_RD: state_r <= S_OS_GOT;
        S_OS_GOT: begin
          pa_r    <= (idx_r == kept_r) ? first_r : rd_r;
          pb_r    <= prev_r;
          mode_r  <= M_SEG;
          state_r <= S_SQX;
        end
        S_SQRT: begin
          it_r <= it_r + ITW'(1);
          if (it_r == ITW'(RW - 1)) begin
            state_r <= S_OS_ACC;
          end
        end
        S_OS_ACC: begin
          walked_r <= (walk_sum > (RW+1)'({WALKW{1'b1}})) ? {WALKW{1'b1}}
                                                          : walk_sum[WALKW-1:0];
          state_r  <= S_OS_EMIT;
        end
        S_OS_EMIT: begin
          if (out_free) begin
            out_x_r     <= pa_r.x[OUTW-1:0];
            out_y_r     <= pa_r.y[OUTW-1:0];
            out_end_r   <= os_end;
            out_rej_r   <= 1'b0;
            out_ovf_r   <= ovf_r;
            k_r         <= k_r + KW'(1);
            idx_r       <= idx_r + KW'(1);
            prev_r      <= pa_r;
            if (os_end) begin
              kept_r      <= '0;
              last_kept_r <= '0;
              ovf_r       <= 1'b0;
              walked_r    <= '0;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_OS_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_point_x         = out_x_r;
  assign out_point_y         = out_y_r;
  assign out_end_of_ring     = out_end_r;
  assign out_ring_rejected   = out_rej_r;
  assign out_vertex_overflow = out_ovf_r;

  a_rej_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ring_rejected |-> out_end_of_ring && out_point_x == '0)
    else $error("rejected word without end of ring");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_vertex_finite || in_last_vertex) |=> in_stall)
    else $error("block ready straight after an accepted word");

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= K_DEPTH)
    else $error("kept count beyond store depth");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x)
      && $stable(out_point_y) && $stable(out_end_of_ring))
    else $error("stalled output word changed");

endmodule
